### hw/rtl/cpcr_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package cpcr_pkg;

  localparam int unsigned COORD_WIDTH_DEF = 32;

  // response coefficient, unsigned Q1.8
  localparam int unsigned COEFF_W = 9;
  localparam logic [COEFF_W-1:0] COEFF_ONE = 9'd256;

  typedef enum logic [1:0] {
    ST_NO_CONTACT  = 2'd0,
    ST_RESOLVED    = 2'd1,
    ST_COINCIDENT  = 2'd2,
    ST_SAME_OBJECT = 2'd3
  } status_e;

endpackage

`default_nettype wire

### hw/rtl/circle_pair_collision_resolver_top.sv
// Circle pair collision resolver, fully pipelined.
// Pipe: front, square root, overlap scaling, share numerators, share divider,
//   move numerators, move divider, output; one root or quotient bit per stage.
// Throughput: one pair per cycle; a two-word output buffer lets one more word
//   enter while a result waits. Stalls freeze the whole pipe.
// Reset: asynchronous, active low; clears valid bits, coefficient to 1.0 (256).
`timescale 1ns / 1ps
`default_nettype none

module circle_pair_collision_resolver_top #(
  parameter int unsigned COORD_WIDTH = cpcr_pkg::COORD_WIDTH_DEF,
  localparam int unsigned IN_DATA_W  = ((6*COORD_WIDTH-2+7)/8)*8,
  localparam int unsigned OUT_DATA_W = ((4*COORD_WIDTH+7)/8)*8
) (
  input  wire                           clk_i,
  input  wire                           rst_ni,
  // input pair words
  input  wire                           s_axis_tvalid_i,
  output logic                          s_axis_tready_o,
  // a_pos_x, a_pos_y, a_radius, b_pos_x, b_pos_y, b_radius, zero pad
  input  wire [IN_DATA_W-1:0]           s_axis_tdata_i,
  // same_object
  input  wire                           s_axis_tuser_i,
  // result words
  output logic                          m_axis_tvalid_o,
  input  wire                           m_axis_tready_i,
  // new_a_x, new_a_y, new_b_x, new_b_y, zero pad
  output logic [OUT_DATA_W-1:0]         m_axis_tdata_o,
  // contact_status
  output logic [1:0]                    m_axis_tuser_o,
  // response_coeff write
  input  wire                           cfg_valid_i,
  output logic                          cfg_ready_o,
  input  wire [cpcr_pkg::COEFF_W-1:0]   cfg_data_i
);
  import cpcr_pkg::*;

  localparam int unsigned W = COORD_WIDTH;

  // sideband that rides along the sqrt pipe
  typedef struct packed {
    logic [W-1:0]       ax;
    logic [W-1:0]       ay;
    logic [W-1:0]       bx;
    logic [W-1:0]       by;
    logic [W-1:0]       mdx;
    logic [W-1:0]       mdy;
    logic               sdx;
    logic               sdy;
    logic [W-1:0]       sum;
    logic [W-2:0]       ra;
    logic [W-2:0]       rb;
    logic [COEFF_W-1:0] k;
    status_e            status;
  } side_a_t;

  // sideband through the share divider
  typedef struct packed {
    logic [W-1:0] ax;
    logic [W-1:0] ay;
    logic [W-1:0] bx;
    logic [W-1:0] by;
    logic [W-1:0] mdx;
    logic [W-1:0] mdy;
    logic         sdx;
    logic         sdy;
    logic [W-1:0] root;
    status_e      status;
  } side_b_t;

  // sideband through the move divider
  typedef struct packed {
    logic [W-1:0] ax;
    logic [W-1:0] ay;
    logic [W-1:0] bx;
    logic [W-1:0] by;
    logic         sdx;
    logic         sdy;
    status_e      status;
  } side_c_t;

  localparam int unsigned SA_W = $bits(side_a_t);
  localparam int unsigned SB_W = $bits(side_b_t);
  localparam int unsigned SC_W = $bits(side_c_t);

  // ---------------------------------------------------------------------------
  // Configuration: coefficient is clamped to 1.0 when written
  // ---------------------------------------------------------------------------
  logic [COEFF_W-1:0] coeff_d, coeff_q;

  assign cfg_ready_o = 1'b1;
  assign coeff_d     = (cfg_data_i > COEFF_ONE) ? COEFF_ONE : cfg_data_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      coeff_q <= COEFF_ONE;
    end else if (cfg_valid_i && cfg_ready_o) begin
      coeff_q <= coeff_d;
    end
  end

  // ---------------------------------------------------------------------------
  // Global advance: the pipe moves whenever the skid slot is free
  // ---------------------------------------------------------------------------
  logic en;
  logic skid_v_d, skid_v_q;

  assign en              = !skid_v_q;
  assign s_axis_tready_o = en;

  // ---------------------------------------------------------------------------
  // Front: differences, squares, overlap test (4 stages)
  // ---------------------------------------------------------------------------
  logic               f_v;
  logic [2*W-1:0]     f_d2;
  side_a_t            f_side;

  cpcr_front #(
    .COORD_WIDTH (COORD_WIDTH)
  ) u_front (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .en_i     (en),
    .valid_i  (s_axis_tvalid_i),
    .a_x_i    (s_axis_tdata_i[W-1:0]),
    .a_y_i    (s_axis_tdata_i[2*W-1:W]),
    .a_r_i    (s_axis_tdata_i[3*W-2:2*W]),
    .b_x_i    (s_axis_tdata_i[4*W-2:3*W-1]),
    .b_y_i    (s_axis_tdata_i[5*W-2:4*W-1]),
    .b_r_i    (s_axis_tdata_i[6*W-3:5*W-1]),
    .k_i      (coeff_q),
    .same_i   (s_axis_tuser_i),
    .valid_o  (f_v),
    .d2_o     (f_d2),
    .a_x_o    (f_side.ax),
    .a_y_o    (f_side.ay),
    .b_x_o    (f_side.bx),
    .b_y_o    (f_side.by),
    .mdx_o    (f_side.mdx),
    .mdy_o    (f_side.mdy),
    .sdx_o    (f_side.sdx),
    .sdy_o    (f_side.sdy),
    .sum_o    (f_side.sum),
    .a_r_o    (f_side.ra),
    .b_r_o    (f_side.rb),
    .k_o      (f_side.k),
    .status_o (f_side.status)
  );

  // ---------------------------------------------------------------------------
  // Distance: floor(sqrt(d2)), W stages. Only resolved pairs need a valid
  // root, and for those d2 < sum^2 < 2^(2W).
  // ---------------------------------------------------------------------------
  logic            q_v;
  logic [W-1:0]    q_root;
  logic [SA_W-1:0] q_side_raw;
  side_a_t         q_side;

  cpcr_sqrt #(
    .COORD_WIDTH (COORD_WIDTH),
    .SIDE_W      (SA_W)
  ) u_sqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (f_v),
    .rad_i   (f_d2),
    .side_i  (f_side),
    .valid_o (q_v),
    .root_o  (q_root),
    .side_o  (q_side_raw)
  );

  assign q_side = q_side_raw;

  // ---------------------------------------------------------------------------
  // Overlap scaling: delta = ((sum - root) * k) >> 9
  // ---------------------------------------------------------------------------
  logic [W-1:0]         ovl_d;
  logic [W+COEFF_W-1:0] dk_d;
  logic                 d_v_q;
  logic [W-1:0]         delta_q;
  logic [W-1:0]         d_sum_q;
  logic [W-2:0]         d_ra_q, d_rb_q;
  side_b_t              d_sb_q;

  assign ovl_d = q_side.sum - q_root;
  assign dk_d  = {{COEFF_W{1'b0}}, ovl_d} * {{W{1'b0}}, q_side.k};

  // ---------------------------------------------------------------------------
  // Share numerators: circle a takes rb/sum, circle b takes ra/sum
  // ---------------------------------------------------------------------------
  logic                      n_v_q;
  logic [1:0][2*W-1:0]       n_num_q;
  logic [W-1:0]              n_sum_q;
  side_b_t                   n_sb_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      d_v_q <= 1'b0;
      n_v_q <= 1'b0;
    end else if (en) begin
      d_v_q <= q_v;
      n_v_q <= d_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      delta_q       <= dk_d[W+COEFF_W-1:COEFF_W];
      d_sum_q       <= q_side.sum;
      d_ra_q        <= q_side.ra;
      d_rb_q        <= q_side.rb;
      d_sb_q.ax     <= q_side.ax;
      d_sb_q.ay     <= q_side.ay;
      d_sb_q.bx     <= q_side.bx;
      d_sb_q.by     <= q_side.by;
      d_sb_q.mdx    <= q_side.mdx;
      d_sb_q.mdy    <= q_side.mdy;
      d_sb_q.sdx    <= q_side.sdx;
      d_sb_q.sdy    <= q_side.sdy;
      d_sb_q.root   <= q_root;
      d_sb_q.status <= q_side.status;

      n_num_q[0] <= {{W{1'b0}}, delta_q} * {{(W+1){1'b0}}, d_rb_q};
      n_num_q[1] <= {{W{1'b0}}, delta_q} * {{(W+1){1'b0}}, d_ra_q};
      n_sum_q    <= d_sum_q;
      n_sb_q     <= d_sb_q;
    end
  end

  // ---------------------------------------------------------------------------
  // Shares: lane 0 for circle a, lane 1 for circle b (W stages)
  // ---------------------------------------------------------------------------
  logic               s_v;
  logic [1:0][W-1:0]  s_share;
  logic [SB_W-1:0]    s_side_raw;
  side_b_t            s_side;

  cpcr_div #(
    .COORD_WIDTH (COORD_WIDTH),
    .LANES       (2),
    .SIDE_W      (SB_W)
  ) u_div_share (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (n_v_q),
    .num_i   (n_num_q),
    .dvs_i   (n_sum_q),
    .side_i  (n_sb_q),
    .valid_o (s_v),
    .quo_o   (s_share),
    .side_o  (s_side_raw)
  );

  assign s_side = s_side_raw;

  // ---------------------------------------------------------------------------
  // Move numerators |d_axis| * share. Lanes: a.x, a.y, b.x, b.y
  // ---------------------------------------------------------------------------
  logic                 p_v_q;
  logic [3:0][2*W-1:0]  p_num_q;
  logic [W-1:0]         p_dist_q;
  side_c_t              p_sc_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p_v_q <= 1'b0;
    end else if (en) begin
      p_v_q <= s_v;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      p_num_q[0]    <= {{W{1'b0}}, s_side.mdx} * {{W{1'b0}}, s_share[0]};
      p_num_q[1]    <= {{W{1'b0}}, s_side.mdy} * {{W{1'b0}}, s_share[0]};
      p_num_q[2]    <= {{W{1'b0}}, s_side.mdx} * {{W{1'b0}}, s_share[1]};
      p_num_q[3]    <= {{W{1'b0}}, s_side.mdy} * {{W{1'b0}}, s_share[1]};
      p_dist_q      <= s_side.root;
      p_sc_q.ax     <= s_side.ax;
      p_sc_q.ay     <= s_side.ay;
      p_sc_q.bx     <= s_side.bx;
      p_sc_q.by     <= s_side.by;
      p_sc_q.sdx    <= s_side.sdx;
      p_sc_q.sdy    <= s_side.sdy;
      p_sc_q.status <= s_side.status;
    end
  end

  // ---------------------------------------------------------------------------
  // Moves: numerator / root (W stages)
  // ---------------------------------------------------------------------------
  logic               m_v;
  logic [3:0][W-1:0]  m_move;
  logic [SC_W-1:0]    m_side_raw;
  side_c_t            m_side;

  cpcr_div #(
    .COORD_WIDTH (COORD_WIDTH),
    .LANES       (4),
    .SIDE_W      (SC_W)
  ) u_div_move (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (p_v_q),
    .num_i   (p_num_q),
    .dvs_i   (p_dist_q),
    .side_i  (p_sc_q),
    .valid_o (m_v),
    .quo_o   (m_move),
    .side_o  (m_side_raw)
  );

  assign m_side = m_side_raw;

  // ---------------------------------------------------------------------------
  // Apply: a moves along +d, b along -d; saturate to W bits.
  // Anything not resolved passes its centers through.
  // ---------------------------------------------------------------------------
  logic [3:0][W-1:0]     base;
  logic [3:0][W-1:0]     res_pos;
  logic [OUT_DATA_W-1:0] res_data;

  assign base = {m_side.by, m_side.bx, m_side.ay, m_side.ax};

  always_comb begin
    logic [W+1:0] pos_ext;
    logic [W+1:0] mv_ext;
    logic [W+1:0] acc;
    logic         neg;
    for (int i = 0; i < 4; i++) begin
      pos_ext = {{2{base[i][W-1]}}, base[i]};
      mv_ext  = {2'b00, m_move[i]};
      // x lanes follow sign of dx, y lanes sign of dy; b lanes subtract
      neg     = ((i % 2 == 0) ? m_side.sdx : m_side.sdy) ^ (i >= 2);
      acc     = neg ? (pos_ext - mv_ext) : (pos_ext + mv_ext);
      if (m_side.status != ST_RESOLVED) begin
        res_pos[i] = base[i];
      end else if ((acc[W+1:W-1] == 3'b000) || (acc[W+1:W-1] == 3'b111)) begin
        res_pos[i] = acc[W-1:0];
      end else if (acc[W+1]) begin
        res_pos[i] = {1'b1, {(W-1){1'b0}}};
      end else begin
        res_pos[i] = {1'b0, {(W-1){1'b1}}};
      end
    end
  end

  assign res_data = OUT_DATA_W'(res_pos);

  // ---------------------------------------------------------------------------
  // Output register plus skid slot
  // ---------------------------------------------------------------------------
  logic                  out_load;
  logic                  out_v_d, out_v_q;
  logic [OUT_DATA_W-1:0] out_data_q, skid_data_q;
  status_e               out_user_q, skid_user_q;

  always_comb begin
    out_load = !out_v_q || m_axis_tready_i;
    out_v_d  = out_v_q;
    skid_v_d = skid_v_q;
    if (out_load) begin
      out_v_d  = skid_v_q || m_v;
      skid_v_d = 1'b0;
    end else if (en && m_v) begin
      skid_v_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q  <= 1'b0;
      skid_v_q <= 1'b0;
    end else begin
      out_v_q  <= out_v_d;
      skid_v_q <= skid_v_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_data_q <= skid_v_q ? skid_data_q : res_data;
      out_user_q <= skid_v_q ? skid_user_q : m_side.status;
    end
    if (en) begin
      skid_data_q <= res_data;
      skid_user_q <= m_side.status;
    end
  end

  assign m_axis_tvalid_o = out_v_q;
  assign m_axis_tdata_o  = out_data_q;
  assign m_axis_tuser_o  = out_user_q;

endmodule

`default_nettype wire

### hw/rtl/cpcr_front.sv
`timescale 1ns / 1ps
`default_nettype none

// Front end: center difference, squares, overlap test. Four stages.
module cpcr_front #(
  parameter int unsigned COORD_WIDTH = cpcr_pkg::COORD_WIDTH_DEF
) (
  input  wire                                clk_i,
  input  wire                                rst_ni,
  input  wire                                en_i,
  input  wire                                valid_i,
  input  wire [COORD_WIDTH-1:0]              a_x_i,
  input  wire [COORD_WIDTH-1:0]              a_y_i,
  input  wire [COORD_WIDTH-2:0]              a_r_i,
  input  wire [COORD_WIDTH-1:0]              b_x_i,
  input  wire [COORD_WIDTH-1:0]              b_y_i,
  input  wire [COORD_WIDTH-2:0]              b_r_i,
  input  wire [cpcr_pkg::COEFF_W-1:0]        k_i,
  input  wire                                same_i,
  output logic                               valid_o,
  output logic [2*COORD_WIDTH-1:0]           d2_o,
  output logic [COORD_WIDTH-1:0]             a_x_o,
  output logic [COORD_WIDTH-1:0]             a_y_o,
  output logic [COORD_WIDTH-1:0]             b_x_o,
  output logic [COORD_WIDTH-1:0]             b_y_o,
  output logic [COORD_WIDTH-1:0]             mdx_o,
  output logic [COORD_WIDTH-1:0]             mdy_o,
  output logic                               sdx_o,
  output logic                               sdy_o,
  output logic [COORD_WIDTH-1:0]             sum_o,
  output logic [COORD_WIDTH-2:0]             a_r_o,
  output logic [COORD_WIDTH-2:0]             b_r_o,
  output logic [cpcr_pkg::COEFF_W-1:0]       k_o,
  output cpcr_pkg::status_e                  status_o
);
  import cpcr_pkg::*;

  localparam int unsigned W = COORD_WIDTH;

  logic v1_q, v2_q, v3_q, v4_q;

  // stage 1: input capture
  logic [W-1:0]       ax1_q, ay1_q, bx1_q, by1_q;
  logic [W-2:0]       ra1_q, rb1_q;
  logic [COEFF_W-1:0] k1_q;
  logic               same1_q;

  // stage 2: differences and magnitudes
  logic [W:0]         dx_d, dy_d, mdx_d, mdy_d;
  logic [W-1:0]       sum_d;
  logic [W-1:0]       ax2_q, ay2_q, bx2_q, by2_q;
  logic [W:0]         mdx2_q, mdy2_q;
  logic               sdx2_q, sdy2_q;
  logic [W-1:0]       sum2_q;
  logic [W-2:0]       ra2_q, rb2_q;
  logic [COEFF_W-1:0] k2_q;
  logic               same2_q;

  // stage 3: squares
  logic [2*W+1:0]     sqx_d, sqy_d;
  logic [2*W-1:0]     ss_d;
  logic [2*W+1:0]     sqx3_q, sqy3_q;
  logic [2*W-1:0]     ss3_q;
  logic [W-1:0]       ax3_q, ay3_q, bx3_q, by3_q;
  logic [W-1:0]       mdx3_q, mdy3_q;
  logic               sdx3_q, sdy3_q;
  logic [W-1:0]       sum3_q;
  logic [W-2:0]       ra3_q, rb3_q;
  logic [COEFF_W-1:0] k3_q;
  logic               same3_q;

  // stage 4: distance squared and classification
  logic [2*W+1:0]     d2_d;
  status_e            status_d;
  logic [2*W-1:0]     d24_q;
  status_e            status4_q;
  logic [W-1:0]       ax4_q, ay4_q, bx4_q, by4_q;
  logic [W-1:0]       mdx4_q, mdy4_q;
  logic               sdx4_q, sdy4_q;
  logic [W-1:0]       sum4_q;
  logic [W-2:0]       ra4_q, rb4_q;
  logic [COEFF_W-1:0] k4_q;

  always_comb begin
    dx_d  = {ax1_q[W-1], ax1_q} - {bx1_q[W-1], bx1_q};
    dy_d  = {ay1_q[W-1], ay1_q} - {by1_q[W-1], by1_q};
    mdx_d = dx_d[W] ? (~dx_d + {{W{1'b0}}, 1'b1}) : dx_d;
    mdy_d = dy_d[W] ? (~dy_d + {{W{1'b0}}, 1'b1}) : dy_d;
    sum_d = {1'b0, ra1_q} + {1'b0, rb1_q};
  end

  assign sqx_d = {{(W+1){1'b0}}, mdx2_q} * {{(W+1){1'b0}}, mdx2_q};
  assign sqy_d = {{(W+1){1'b0}}, mdy2_q} * {{(W+1){1'b0}}, mdy2_q};
  assign ss_d  = {{W{1'b0}}, sum2_q} * {{W{1'b0}}, sum2_q};

  always_comb begin
    d2_d = sqx3_q + sqy3_q;
    if (same3_q) begin
      status_d = ST_SAME_OBJECT;
    end else if (d2_d >= {2'b00, ss3_q}) begin
      status_d = ST_NO_CONTACT;
    end else if (d2_d == '0) begin
      status_d = ST_COINCIDENT;
    end else begin
      status_d = ST_RESOLVED;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
    end else if (en_i) begin
      v1_q <= valid_i;
      v2_q <= v1_q;
      v3_q <= v2_q;
      v4_q <= v3_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      ax1_q   <= a_x_i;
      ay1_q   <= a_y_i;
      bx1_q   <= b_x_i;
      by1_q   <= b_y_i;
      ra1_q   <= a_r_i;
      rb1_q   <= b_r_i;
      k1_q    <= k_i;
      same1_q <= same_i;

      ax2_q   <= ax1_q;
      ay2_q   <= ay1_q;
      bx2_q   <= bx1_q;
      by2_q   <= by1_q;
      mdx2_q  <= mdx_d;
      mdy2_q  <= mdy_d;
      sdx2_q  <= dx_d[W];
      sdy2_q  <= dy_d[W];
      sum2_q  <= sum_d;
      ra2_q   <= ra1_q;
      rb2_q   <= rb1_q;
      k2_q    <= k1_q;
      same2_q <= same1_q;

      sqx3_q  <= sqx_d;
      sqy3_q  <= sqy_d;
      ss3_q   <= ss_d;
      ax3_q   <= ax2_q;
      ay3_q   <= ay2_q;
      bx3_q   <= bx2_q;
      by3_q   <= by2_q;
      mdx3_q  <= mdx2_q[W-1:0];
      mdy3_q  <= mdy2_q[W-1:0];
      sdx3_q  <= sdx2_q;
      sdy3_q  <= sdy2_q;
      sum3_q  <= sum2_q;
      ra3_q   <= ra2_q;
      rb3_q   <= rb2_q;
      k3_q    <= k2_q;
      same3_q <= same2_q;

      d24_q     <= d2_d[2*W-1:0];
      status4_q <= status_d;
      ax4_q     <= ax3_q;
      ay4_q     <= ay3_q;
      bx4_q     <= bx3_q;
      by4_q     <= by3_q;
      mdx4_q    <= mdx3_q;
      mdy4_q    <= mdy3_q;
      sdx4_q    <= sdx3_q;
      sdy4_q    <= sdy3_q;
      sum4_q    <= sum3_q;
      ra4_q     <= ra3_q;
      rb4_q     <= rb3_q;
      k4_q      <= k3_q;
    end
  end

  assign valid_o  = v4_q;
  assign d2_o     = d24_q;
  assign a_x_o    = ax4_q;
  assign a_y_o    = ay4_q;
  assign b_x_o    = bx4_q;
  assign b_y_o    = by4_q;
  assign mdx_o    = mdx4_q;
  assign mdy_o    = mdy4_q;
  assign sdx_o    = sdx4_q;
  assign sdy_o    = sdy4_q;
  assign sum_o    = sum4_q;
  assign a_r_o    = ra4_q;
  assign b_r_o    = rb4_q;
  assign k_o      = k4_q;
  assign status_o = status4_q;

endmodule

`default_nettype wire

### hw/rtl/cpcr_sqrt.sv
`timescale 1ns / 1ps
`default_nettype none

// Pipelined integer square root, one root bit per stage.
module cpcr_sqrt #(
  parameter int unsigned COORD_WIDTH = cpcr_pkg::COORD_WIDTH_DEF,
  parameter int unsigned SIDE_W      = 1
) (
  input  wire                         clk_i,
  input  wire                         rst_ni,
  input  wire                         en_i,
  input  wire                         valid_i,
  input  wire [2*COORD_WIDTH-1:0]     rad_i,
  input  wire [SIDE_W-1:0]            side_i,
  output logic                        valid_o,
  output logic [COORD_WIDTH-1:0]      root_o,
  output logic [SIDE_W-1:0]           side_o
);

  localparam int unsigned W = COORD_WIDTH;

  logic [W-1:0]                v_in, v_q;
  logic [W-1:0][W+1:0]         rem_in, rem_d, rem_q;
  logic [W-1:0][W-1:0]         root_in, root_d, root_q;
  logic [W-1:0][2*W-1:0]       rad_in, rad_d, rad_q;
  logic [W-1:0][SIDE_W-1:0]    side_in, side_q;

  always_comb begin
    logic [W+1:0] sh;
    logic [W+1:0] trial;
    logic         ge;
    v_in[0]    = valid_i;
    rem_in[0]  = '0;
    root_in[0] = '0;
    rad_in[0]  = rad_i;
    side_in[0] = side_i;
    for (int j = 1; j < W; j++) begin
      v_in[j]    = v_q[j-1];
      rem_in[j]  = rem_q[j-1];
      root_in[j] = root_q[j-1];
      rad_in[j]  = rad_q[j-1];
      side_in[j] = side_q[j-1];
    end
    for (int j = 0; j < W; j++) begin
      sh         = {rem_in[j][W-1:0], rad_in[j][2*W-1:2*W-2]};
      trial      = {root_in[j], 2'b01};
      ge         = (sh >= trial);
      rem_d[j]   = ge ? (sh - trial) : sh;
      root_d[j]  = {root_in[j][W-2:0], ge};
      rad_d[j]   = {rad_in[j][2*W-3:0], 2'b00};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (en_i) begin
      v_q <= v_in;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rem_q  <= rem_d;
      root_q <= root_d;
      rad_q  <= rad_d;
      side_q <= side_in;
    end
  end

  assign valid_o = v_q[W-1];
  assign root_o  = root_q[W-1];
  assign side_o  = side_q[W-1];

endmodule

`default_nettype wire

### hw/rtl/cpcr_div.sv
`timescale 1ns / 1ps
`default_nettype none

// Pipelined restoring divider, one quotient bit per stage, lanes share
// one divisor. Numerator must be below divisor << COORD_WIDTH.
module cpcr_div #(
  parameter int unsigned COORD_WIDTH = cpcr_pkg::COORD_WIDTH_DEF,
  parameter int unsigned LANES       = 2,
  parameter int unsigned SIDE_W      = 1
) (
  input  wire                                      clk_i,
  input  wire                                      rst_ni,
  input  wire                                      en_i,
  input  wire                                      valid_i,
  input  wire [LANES-1:0][2*COORD_WIDTH-1:0]       num_i,
  input  wire [COORD_WIDTH-1:0]                    dvs_i,
  input  wire [SIDE_W-1:0]                         side_i,
  output logic                                     valid_o,
  output logic [LANES-1:0][COORD_WIDTH-1:0]        quo_o,
  output logic [SIDE_W-1:0]                        side_o
);

  localparam int unsigned W = COORD_WIDTH;

  logic [W-1:0]                        v_in, v_q;
  logic [W-1:0][W-1:0]                 dvs_in, dvs_q;
  logic [W-1:0][SIDE_W-1:0]            side_in, side_q;
  logic [W-1:0][LANES-1:0][W-1:0]      rem_in, rem_d, rem_q;
  logic [W-1:0][LANES-1:0][W-1:0]      low_in, low_d, low_q;
  logic [W-1:0][LANES-1:0][W-1:0]      quo_in, quo_d, quo_q;

  always_comb begin
    logic [W:0] sh;
    logic [W:0] diff;
    logic       ge;
    v_in[0]    = valid_i;
    dvs_in[0]  = dvs_i;
    side_in[0] = side_i;
    for (int l = 0; l < LANES; l++) begin
      rem_in[0][l] = num_i[l][2*W-1:W];
      low_in[0][l] = num_i[l][W-1:0];
      quo_in[0][l] = '0;
    end
    for (int j = 1; j < W; j++) begin
      v_in[j]    = v_q[j-1];
      dvs_in[j]  = dvs_q[j-1];
      side_in[j] = side_q[j-1];
      rem_in[j]  = rem_q[j-1];
      low_in[j]  = low_q[j-1];
      quo_in[j]  = quo_q[j-1];
    end
    for (int j = 0; j < W; j++) begin
      for (int l = 0; l < LANES; l++) begin
        sh          = {rem_in[j][l], low_in[j][l][W-1]};
        diff        = sh - {1'b0, dvs_in[j]};
        ge          = (sh >= {1'b0, dvs_in[j]});
        rem_d[j][l] = ge ? diff[W-1:0] : sh[W-1:0];
        low_d[j][l] = {low_in[j][l][W-2:0], 1'b0};
        quo_d[j][l] = {quo_in[j][l][W-2:0], ge};
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (en_i) begin
      v_q <= v_in;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      dvs_q  <= dvs_in;
      side_q <= side_in;
      rem_q  <= rem_d;
      low_q  <= low_d;
      quo_q  <= quo_d;
    end
  end

  assign valid_o = v_q[W-1];
  assign quo_o   = quo_q[W-1];
  assign side_o  = side_q[W-1];

endmodule

`default_nettype wire

### hw/rtl/cpcr_checker.sv
`timescale 1ns / 1ps
`default_nettype none

module cpcr_checker #(
  parameter int unsigned COORD_WIDTH = cpcr_pkg::COORD_WIDTH_DEF,
  localparam int unsigned OUT_DATA_W = ((4*COORD_WIDTH+7)/8)*8
) (
  input wire                  clk_i,
  input wire                  rst_ni,
  input wire                  s_axis_tvalid_i,
  input wire                  s_axis_tready_o,
  input wire                  m_axis_tvalid_o,
  input wire                  m_axis_tready_i,
  input wire [OUT_DATA_W-1:0] m_axis_tdata_o,
  input wire [1:0]            m_axis_tuser_o
);

  // a stalled result word holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=>
      m_axis_tvalid_o && $stable(m_axis_tdata_o) && $stable(m_axis_tuser_o))
    else $error("result word changed while stalled");

  // input only blocks when both output slots are full
  a_stall_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready_o |-> m_axis_tvalid_o)
    else $error("input blocked with empty output");

  // ready drops only after an output stall
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(s_axis_tready_o) |-> $past(m_axis_tvalid_o && !m_axis_tready_i))
    else $error("input ready dropped without output stall");

  // empty output means the skid slot is free next cycle
  a_empty_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !m_axis_tvalid_o |=> s_axis_tready_o)
    else $error("input not ready after empty output");

endmodule

bind circle_pair_collision_resolver_top cpcr_checker #(
  .COORD_WIDTH (COORD_WIDTH)
) u_cpcr_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .s_axis_tvalid_i (s_axis_tvalid_i),
  .s_axis_tready_o (s_axis_tready_o),
  .m_axis_tvalid_o (m_axis_tvalid_o),
  .m_axis_tready_i (m_axis_tready_i),
  .m_axis_tdata_o  (m_axis_tdata_o),
  .m_axis_tuser_o  (m_axis_tuser_o)
);

`default_nettype wire

### test/circle_pair_collision_resolver_top_tb.sv
`timescale 1ns / 1ps

module circle_pair_collision_resolver_top_tb;
  import cpcr_pkg::*;

  typedef struct packed {
    logic signed [31:0] ax;
    logic signed [31:0] ay;
    logic [30:0]        ra;
    logic signed [31:0] bx;
    logic signed [31:0] by;
    logic [30:0]        rb;
    logic               same;
  } pair_t;

  typedef struct packed {
    logic signed [31:0] ax;
    logic signed [31:0] ay;
    logic signed [31:0] bx;
    logic signed [31:0] by;
    status_e            status;
  } centers_t;

  // directed row: typed expectation only where has_exp is set
  typedef struct packed {
    pair_t    pair;
    logic     has_exp;
    centers_t exp;
  } row_t;

  localparam logic signed [31:0] PMAX = 32'sh7FFF_FFFF;
  localparam logic signed [31:0] PMIN = 32'sh8000_0000;
  localparam logic [30:0]        RMAX = 31'h7FFF_FFFF;
  localparam logic [30:0]        ONE  = 31'h1_0000;

  logic         clk_i = 1'b0;
  logic         rst_ni = 1'b0;
  logic         s_axis_tvalid_i = 1'b0;
  logic         s_axis_tready_o;
  logic [191:0] s_axis_tdata_i = '0;
  logic         s_axis_tuser_i = 1'b0;
  logic         m_axis_tvalid_o;
  logic         m_axis_tready_i = 1'b0;
  logic [127:0] m_axis_tdata_o;
  logic [1:0]   m_axis_tuser_o;
  logic         cfg_valid_i = 1'b0;
  logic         cfg_ready_o;
  logic [COEFF_W-1:0] cfg_data_i = '0;

  circle_pair_collision_resolver_top uut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .s_axis_tvalid_i(s_axis_tvalid_i),
    .s_axis_tready_o(s_axis_tready_o),
    .s_axis_tdata_i (s_axis_tdata_i),
    .s_axis_tuser_i (s_axis_tuser_i),
    .m_axis_tvalid_o(m_axis_tvalid_o),
    .m_axis_tready_i(m_axis_tready_i),
    .m_axis_tdata_o (m_axis_tdata_o),
    .m_axis_tuser_o (m_axis_tuser_o),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_ready_o    (cfg_ready_o),
    .cfg_data_i     (cfg_data_i)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // run limit, far above the slowest legal run
  initial begin
    #20_000_000;
    $display("Test completed with failures");
    $finish;
  end

  centers_t     pending_q[$];   // expected result words, oldest first
  logic [8:0]   coeff = COEFF_ONE;  // shadow of response_coeff
  int           n_errors = 0;
  bit           quiet = 1'b0;   // no idling on either side while set

  task automatic report_mismatch(input string msg);
    $display("ERROR @%0t: %s", $realtime, msg);
    n_errors++;
  endtask

  function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
    if (v > 64'sh7FFF_FFFF) return PMAX;
    if (v < -64'sh8000_0000) return PMIN;
    return v[31:0];
  endfunction

  // |diff| * share / root, carrying the sign of diff
  function automatic logic signed [63:0] axis_shift(input logic signed [63:0] diff,
                                                     input logic [127:0] share,
                                                     input logic [127:0] root);
    logic [127:0] m;
    m = ({64'd0, (diff < 0) ? -diff : diff} * share) / root;
    return (diff < 0) ? -$signed(m[63:0]) : $signed(m[63:0]);
  endfunction

  function automatic centers_t resolve_pair(input pair_t p, input logic [8:0] k_reg);
    centers_t r;
    logic signed [63:0] ax, ay, bx, by, dx, dy;
    logic [63:0]  mdx, mdy;
    logic [127:0] d2, s, root, cand, k, delta, sha, shb;
    ax = p.ax; ay = p.ay; bx = p.bx; by = p.by;
    r.ax = p.ax; r.ay = p.ay; r.bx = p.bx; r.by = p.by;
    if (p.same) begin
      r.status = ST_SAME_OBJECT;
      return r;
    end
    dx = ax - bx;
    dy = ay - by;
    mdx = (dx < 0) ? -dx : dx;
    mdy = (dy < 0) ? -dy : dy;
    d2 = {64'd0, mdx} * {64'd0, mdx} + {64'd0, mdy} * {64'd0, mdy};
    s = {97'd0, p.ra} + {97'd0, p.rb};
    if (d2 >= s * s) begin
      r.status = ST_NO_CONTACT;
    end else if (d2 == 0) begin
      r.status = ST_COINCIDENT;
    end else begin
      root = '0;
      for (int b = 63; b >= 0; b--) begin
        cand = root | (128'd1 << b);
        if (cand * cand <= d2) root = cand;
      end
      k = (k_reg > COEFF_ONE) ? 128'(COEFF_ONE) : 128'(k_reg);
      delta = ((s - root) * k) >> 9;
      sha = (delta * {97'd0, p.rb}) / s;
      shb = (delta * {97'd0, p.ra}) / s;
      r.ax = sat32(ax + axis_shift(dx, sha, root));
      r.ay = sat32(ay + axis_shift(dy, sha, root));
      r.bx = sat32(bx - axis_shift(dx, shb, root));
      r.by = sat32(by - axis_shift(dy, shb, root));
      r.status = ST_RESOLVED;
    end
    return r;
  endfunction

  // result side: check each accepted word, then pick the next tready
  always @(posedge clk_i) begin
    centers_t got, want;
    if (m_axis_tvalid_o && m_axis_tready_i) begin
      got.ax = m_axis_tdata_o[31:0];
      got.ay = m_axis_tdata_o[63:32];
      got.bx = m_axis_tdata_o[95:64];
      got.by = m_axis_tdata_o[127:96];
      got.status = status_e'(m_axis_tuser_o);
      if (pending_q.size() == 0) begin
        report_mismatch("result word with nothing expected");
      end else begin
        want = pending_q.pop_front();
        if (got.ax !== want.ax)
          report_mismatch($sformatf("new_a_x %0d, want %0d", got.ax, want.ax));
        if (got.ay !== want.ay)
          report_mismatch($sformatf("new_a_y %0d, want %0d", got.ay, want.ay));
        if (got.bx !== want.bx)
          report_mismatch($sformatf("new_b_x %0d, want %0d", got.bx, want.bx));
        if (got.by !== want.by)
          report_mismatch($sformatf("new_b_y %0d, want %0d", got.by, want.by));
        if (got.status !== want.status)
          report_mismatch($sformatf("status %0d, want %0d", got.status, want.status));
      end
    end
    m_axis_tready_i <= quiet || ($urandom_range(0, 99) >= 19);
  end

  // push one pair; valid stays high into the next call unless a gap is drawn
  task automatic send_pair(input pair_t p, input logic has_exp, input centers_t exp);
    while (!quiet && $urandom_range(0, 99) < 19) begin
      s_axis_tvalid_i <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i  <= {2'b00, p.rb, p.by, p.bx, p.ra, p.ay, p.ax};
    s_axis_tuser_i  <= p.same;
    do @(posedge clk_i); while (!s_axis_tready_o);
    pending_q.push_back(has_exp ? exp : resolve_pair(p, coeff));
  endtask

  // stop sending and let every expected word come back
  task automatic drain;
    s_axis_tvalid_i <= 1'b0;
    @(posedge clk_i);
    while (pending_q.size() != 0) @(posedge clk_i);
  endtask

  task automatic write_coeff(input logic [8:0] v);
    drain();
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= v;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    coeff = v;
  endtask

  // random pair: mostly close pairs likely to overlap, some coincident centers, plus full-range noise
  function automatic pair_t rand_pair;
    pair_t p;
    int    mode;
    mode = $urandom_range(0, 99);
    p.bx = $urandom;
    p.by = $urandom;
    p.ax = $urandom;
    p.ay = $urandom;
    p.ra = 31'($urandom);
    p.rb = 31'($urandom);
    p.same = ($urandom_range(0, 99) < 6);
    if (mode < 70) begin
      // nearby centers, radii at a comparable random scale
      p.ax = p.bx + ($signed(32'($urandom)) >>> $urandom_range(1, 31));
      p.ay = p.by + ($signed(32'($urandom)) >>> $urandom_range(1, 31));
      p.ra = p.ra >> $urandom_range(0, 30);
      p.rb = p.rb >> $urandom_range(0, 30);
    end else if (mode < 78) begin
      p.ax = p.bx;
      p.ay = p.by;
    end
    return p;
  endfunction

  // pass-through expectation
  function automatic centers_t keep(input pair_t p, input status_e st);
    centers_t r;
    r.ax = p.ax; r.ay = p.ay; r.bx = p.bx; r.by = p.by; r.status = st;
    return r;
  endfunction

  function automatic pair_t mk(input logic signed [31:0] ax, ay, input logic [30:0] ra,
                               input logic signed [31:0] bx, by, input logic [30:0] rb,
                               input logic same);
    pair_t p;
    p.ax = ax; p.ay = ay; p.ra = ra; p.bx = bx; p.by = by; p.rb = rb; p.same = same;
    return p;
  endfunction

  row_t rows[$];

  initial begin
    pair_t p;
    logic [8:0] phase_coeff[7];
    centers_t none;

    none = '0;
    phase_coeff = '{9'd0, 9'd128, 9'd511, 9'd300, 9'd1, 9'd256, 9'd0};
    phase_coeff[6] = $urandom_range(0, 511);

    // same object: untouched even when overlapping, status same object
    p = mk(PMAX, PMIN, RMAX, PMIN, PMAX, RMAX, 1'b1);
    rows.push_back('{p, 1'b1, keep(p, ST_SAME_OBJECT)});
    p = mk(0, 0, ONE, 0, 0, ONE, 1'b1);
    rows.push_back('{p, 1'b1, keep(p, ST_SAME_OBJECT)});
    // two zero radii at one point: no contact
    p = mk(0, 0, 0, 0, 0, 0, 1'b0);
    rows.push_back('{p, 1'b1, keep(p, ST_NO_CONTACT)});
    p = mk(PMIN, PMIN, 0, PMIN, PMIN, 0, 1'b0);
    rows.push_back('{p, 1'b1, keep(p, ST_NO_CONTACT)});
    // coincident centers with radius
    p = mk(PMAX, PMAX, RMAX, PMAX, PMAX, RMAX, 1'b0);
    rows.push_back('{p, 1'b1, keep(p, ST_COINCIDENT)});
    p = mk(-5, 7, 0, -5, 7, 1, 1'b0);
    rows.push_back('{p, 1'b1, keep(p, ST_COINCIDENT)});
    // opposite corners, largest radii: still apart
    p = mk(PMAX, PMAX, RMAX, PMIN, PMIN, RMAX, 1'b0);
    rows.push_back('{p, 1'b1, keep(p, ST_NO_CONTACT)});
    // exactly touching: no contact
    p = mk(0, 0, ONE, 32'sh2_0000, 0, ONE, 1'b0);
    rows.push_back('{p, 1'b1, keep(p, ST_NO_CONTACT)});
    // overlaps left to the predictor
    rows.push_back('{mk(0, 0, ONE, 32'sh1_0000, 0, ONE, 1'b0), 1'b0, none});
    rows.push_back('{mk(0, 0, ONE, 0, -32'sh8000, 0, 1'b0), 1'b0, none});
    rows.push_back('{mk(3, -4, 0, 0, 0, 6, 1'b0), 1'b0, none});
    rows.push_back('{mk(PMAX, 0, RMAX, PMAX - 1, 0, RMAX, 1'b0), 1'b0, none});
    rows.push_back('{mk(PMIN, PMIN, RMAX, PMIN + 1, PMIN + 1, RMAX, 1'b0), 1'b0, none});
    rows.push_back('{mk(PMAX, PMIN, RMAX, PMAX, PMIN + 1, 0, 1'b0), 1'b0, none});
    rows.push_back('{mk(-1, -1, 1, 0, 0, 1, 1'b0), 1'b0, none});
    rows.push_back('{mk(0, 1, RMAX, 0, 0, RMAX, 1'b0), 1'b0, none});
    rows.push_back('{mk(32'sh0F0F_0F0F, 32'shF0F0_F0F0, 31'h5555_5555,
                        32'sh1234_5678, 32'shEDCB_A987, 31'h2AAA_AAAA, 1'b0), 1'b0, none});

    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed pass at the reset coefficient
    foreach (rows[i]) send_pair(rows[i].pair, rows[i].has_exp, rows[i].exp);

    // random phases, each at a new coefficient; one phase runs without idling
    foreach (phase_coeff[ph]) begin
      write_coeff(phase_coeff[ph]);
      quiet = (ph == 2);
      for (int n = 0; n < 105; n++) begin
        send_pair(rand_pair(), 1'b0, none);
        // now and then hold off until the pipe runs dry
        if ($urandom_range(0, 99) == 0) drain();
      end
      quiet = 1'b0;
    end

    drain();
    repeat (120) @(posedge clk_i);
    if (n_errors == 0)
      $display("Test completed successfully");
    else
      $display("Test completed with failures");
    $finish;
  end

endmodule

### files.f
hw/rtl/cpcr_pkg.sv
hw/rtl/cpcr_front.sv
hw/rtl/cpcr_sqrt.sv
hw/rtl/cpcr_div.sv
hw/rtl/circle_pair_collision_resolver_top.sv
hw/rtl/cpcr_checker.sv
test/circle_pair_collision_resolver_top_tb.sv
